// ===== rtl/frna_pkg.sv =====
// Shared types, constants and control structs for the fractional-N ratio approximator.
package frna_pkg;

	localparam int IN_W      = 40;
	localparam int N_W       = 12;
	localparam int REF_W     = 27;
	localparam int DEN_W     = 22;
	localparam int IP_W      = 16;
	localparam int ST_W      = 2;
	localparam int CFG_W     = 27;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W     = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int HALF_W    = DIV_W / 2;
	localparam int MULB_W    = 23;
	localparam int PP_W      = HALF_W + MULB_W;
	localparam int TINY_SHIFT = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXDEN    = 2'd2;

	localparam logic [N_W-1:0]   RST_DIVIDER   = 12'd341;
	localparam logic [REF_W-1:0] RST_REFERENCE = 27'd10000000;
	localparam logic [DEN_W-1:0] RST_MAXDEN    = 22'd4194303;

	typedef logic [ST_W-1:0] status_t;
	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_LOW = 2'd1;
	localparam status_t ST_OVR = 2'd2;

	typedef enum logic [1:0] {
		DSEL_EUCLID = 2'd0,
		DSEL_SEMI   = 2'd1,
		DSEL_FINAL  = 2'd2
	} dsel_t;

	typedef enum logic {
		MSEL_K = 1'b0,
		MSEL_H = 1'b1
	} msel_t;

	typedef enum logic [1:0] {
		MS_IDLE = 2'd0,
		MS_LO   = 2'd1,
		MS_HI   = 2'd2,
		MS_SUM  = 2'd3
	} mstep_t;

	typedef struct packed {
		logic   capture;
		logic   base_mul;
		logic   init;
		logic   div_start;
		dsel_t  div_sel;
		logic   take_q;
		logic   first_upd;
		msel_t  mul_sel;
		mstep_t mul_step;
		logic   kn_load;
		logic   conv_upd;
		logic   advance;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic tgt_low;
		logic div_done;
		logic q_big;
		logic k1_zero;
		logic kn_over;
		logic rem_stop;
		logic terms_last;
		logic h_zero;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/frna_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module frna_div import frna_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DIV_W-1:0] remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = ~diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");
`endif

endmodule

// ===== rtl/frna_dp.sv =====
// Datapath: config registers, Euclid operands, convergents, multiplier and result register.
module frna_dp import frna_pkg::*; #(
	parameter int FRAC_BITS = 8,
	parameter int MAX_TERMS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [IN_W-1:0]      target_freq,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [DEN_W-1:0]     frac_numerator,
	output logic [DEN_W-1:0]     frac_denominator,
	output logic [IP_W-1:0]      integer_part,
	output logic [ST_W-1:0]      status
);

	localparam int BASE_W = N_W + REF_W;
	localparam int BW     = BASE_W + FRAC_BITS;
	localparam int CW     = (BW > IN_W) ? BW : IN_W;
	localparam int BVW    = REF_W + FRAC_BITS;
	localparam int AW     = (BVW > IN_W) ? BVW : IN_W;
	localparam int TW     = AW + TINY_SHIFT;
	localparam int NT_W   = $clog2(MAX_TERMS);

	logic [N_W-1:0]    divider_q;
	logic [REF_W-1:0]  reference_q;
	logic [DEN_W-1:0]  maxden_q;
	logic [REF_W-1:0]  ref_eff;
	logic [DEN_W-1:0]  lim_eff;

	logic [IN_W-1:0]   tgt_q;
	logic [BASE_W-1:0] base_q;
	logic [BW-1:0]     base_sh;
	logic [AW-1:0]     a_q;
	logic [AW-1:0]     b_q;
	logic [AW-1:0]     r_q;
	logic [DIV_W-1:0]  q_q;
	logic [DIV_W-1:0]  h1_q;
	logic [DIV_W-1:0]  h0_q;
	logic [DEN_W-1:0]  k1_q;
	logic [DEN_W-1:0]  k0_q;
	logic [DEN_W-1:0]  kn_q;
	logic [NT_W-1:0]   n_q;
	logic [PP_W-1:0]   pp_q;
	logic [DIV_W-1:0]  acc_q;

	logic [DIV_W-1:0]  mul_a;
	logic [DIV_W-1:0]  mul_add;
	logic [MULB_W-1:0] mul_b;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [DIV_W-1:0]  div_rem;
	logic [TW-1:0]     tiny_prod;

	logic              out_valid_q;
	logic [DEN_W-1:0]  frac_numerator_q;
	logic [DEN_W-1:0]  frac_denominator_q;
	logic [IP_W-1:0]   integer_part_q;
	status_t           status_q;

	assign ref_eff = (reference_q == '0) ? REF_W'(1) : reference_q;
	assign lim_eff = (maxden_q == '0) ? DEN_W'(1) : maxden_q;
	assign base_sh = BW'(base_q) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q   <= RST_DIVIDER;
			reference_q <= RST_REFERENCE;
			maxden_q    <= RST_MAXDEN;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DIVIDER:   divider_q   <= cfg_data[N_W-1:0];
				CFG_REFERENCE: reference_q <= cfg_data[REF_W-1:0];
				CFG_MAXDEN:    maxden_q    <= cfg_data[DEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cmd.mul_sel == MSEL_K) begin
			mul_a   = DIV_W'(k1_q);
			mul_add = DIV_W'(k0_q);
		end else begin
			mul_a   = h1_q;
			mul_add = h0_q;
		end
		mul_b = q_q[MULB_W-1:0];
	end

	always_comb begin
		case (cmd.div_sel)
			DSEL_SEMI: begin
				div_dividend = DIV_W'(lim_eff - k0_q);
				div_divisor  = DIV_W'(k1_q);
			end
			DSEL_FINAL: begin
				div_dividend = h1_q;
				div_divisor  = DIV_W'(k1_q);
			end
			default: begin
				div_dividend = DIV_W'(a_q);
				div_divisor  = DIV_W'(b_q);
			end
		endcase
	end

	frna_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tgt_q <= target_freq;
		end
		if (cmd.base_mul) begin
			base_q <= divider_q * ref_eff;
		end
		if (cmd.init) begin
			a_q  <= AW'(CW'(tgt_q) - CW'(base_sh));
			b_q  <= AW'(ref_eff) << FRAC_BITS;
			h1_q <= DIV_W'(1);
			h0_q <= '0;
			k1_q <= '0;
			k0_q <= DEN_W'(1);
			n_q  <= '0;
		end
		if (cmd.take_q) begin
			q_q <= div_quo;
			r_q <= div_rem[AW-1:0];
		end
		if (cmd.first_upd) begin
			h0_q <= h1_q;
			h1_q <= q_q;
			k0_q <= k1_q;
			k1_q <= k0_q;
		end
		case (cmd.mul_step)
			MS_LO: pp_q <= mul_a[HALF_W-1:0] * mul_b;
			MS_HI: begin
				acc_q <= DIV_W'(pp_q) + mul_add;
				pp_q  <= mul_a[DIV_W-1:HALF_W] * mul_b;
			end
			MS_SUM: acc_q <= acc_q + {pp_q[HALF_W-1:0], {HALF_W{1'b0}}};
			default: ;
		endcase
		if (cmd.kn_load) begin
			kn_q <= acc_q[DEN_W-1:0];
		end
		if (cmd.conv_upd) begin
			h0_q <= h1_q;
			h1_q <= acc_q;
			k0_q <= k1_q;
			k1_q <= kn_q;
		end
		if (cmd.advance) begin
			a_q <= b_q;
			b_q <= r_q;
			n_q <= n_q + NT_W'(1);
		end
	end

	assign tiny_prod = (TW'(r_q) << TINY_SHIFT) - TW'(r_q);

	always_comb begin
		sts.tgt_low    = CW'(tgt_q) < CW'(base_sh);
		sts.div_done   = div_done;
		sts.q_big      = |q_q[DIV_W-1:MULB_W];
		sts.k1_zero    = (k1_q == '0);
		sts.kn_over    = acc_q > DIV_W'(lim_eff);
		sts.rem_stop   = (r_q == '0) || (tiny_prod < TW'(b_q));
		sts.terms_last = (n_q == NT_W'(MAX_TERMS - 1));
		sts.h_zero     = (h1_q == '0) || (k1_q == '0);
		sts.out_busy   = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (sts.tgt_low) begin
				frac_numerator_q   <= '0;
				frac_denominator_q <= '0;
				integer_part_q     <= '0;
				status_q           <= ST_LOW;
			end else begin
				frac_numerator_q   <= div_rem[DEN_W-1:0];
				frac_denominator_q <= k1_q;
				if (|div_quo[DIV_W-1:IP_W]) begin
					integer_part_q <= '1;
					status_q       <= ST_OVR;
				end else begin
					integer_part_q <= div_quo[IP_W-1:0];
					status_q       <= ST_OK;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign frac_numerator   = frac_numerator_q;
	assign frac_denominator = frac_denominator_q;
	assign integer_part     = integer_part_q;
	assign status           = status_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && out_valid_q |-> out_ready)
		else $error("pending result overwritten");
	a_den_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_upd |-> kn_q <= lim_eff)
		else $error("denominator convergent past limit");
`endif

endmodule

// ===== rtl/frna_ctrl.sv =====
// Controller: sequences Euclid terms, convergent updates, semi-convergent and final split.
module frna_ctrl import frna_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_BASE  = 16'h0002,
		S_CHECK = 16'h0004,
		S_DIVGO = 16'h0008,
		S_DIVW  = 16'h0010,
		S_TERM  = 16'h0020,
		S_KHI   = 16'h0040,
		S_KSUM  = 16'h0080,
		S_KCMP  = 16'h0100,
		S_HHI   = 16'h0200,
		S_HSUM  = 16'h0400,
		S_HUPD  = 16'h0800,
		S_STOP  = 16'h1000,
		S_FIN   = 16'h2000,
		S_FDIVW = 16'h4000,
		S_OUT   = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   semi_q;
	logic   semi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			semi_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			semi_q  <= semi_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		semi_d  = semi_q;
		cmd     = '{default: '0, div_sel: DSEL_EUCLID, mul_sel: MSEL_K, mul_step: MS_IDLE};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					semi_d      = 1'b0;
					state_d     = S_BASE;
				end
			end
			S_BASE: begin
				cmd.base_mul = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				if (sts.tgt_low) begin
					state_d = S_OUT;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_DIVGO;
				end
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_EUCLID;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.take_q = 1'b1;
					state_d    = S_TERM;
				end
			end
			S_TERM: begin
				if (sts.k1_zero) begin
					cmd.first_upd = 1'b1;
					state_d       = S_STOP;
				end else if (sts.q_big) begin
					state_d = S_FIN;
				end else begin
					cmd.mul_sel  = MSEL_K;
					cmd.mul_step = MS_LO;
					state_d      = S_KHI;
				end
			end
			S_KHI: begin
				cmd.mul_sel  = MSEL_K;
				cmd.mul_step = MS_HI;
				state_d      = S_KSUM;
			end
			S_KSUM: begin
				cmd.mul_step = MS_SUM;
				state_d      = S_KCMP;
			end
			S_KCMP: begin
				if (sts.kn_over) begin
					state_d = S_FIN;
				end else begin
					cmd.kn_load  = 1'b1;
					cmd.mul_sel  = MSEL_H;
					cmd.mul_step = MS_LO;
					state_d      = S_HHI;
				end
			end
			S_HHI: begin
				cmd.mul_sel  = MSEL_H;
				cmd.mul_step = MS_HI;
				state_d      = S_HSUM;
			end
			S_HSUM: begin
				cmd.mul_step = MS_SUM;
				state_d      = S_HUPD;
			end
			S_HUPD: begin
				cmd.conv_upd = 1'b1;
				state_d      = semi_q ? S_FIN : S_STOP;
			end
			S_STOP: begin
				if (sts.rem_stop || sts.terms_last) begin
					state_d = S_FIN;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_DIVGO;
				end
			end
			S_FIN: begin
				cmd.div_start = 1'b1;
				if (!semi_q && sts.h_zero) begin
					cmd.div_sel = DSEL_SEMI;
					semi_d      = 1'b1;
					state_d     = S_DIVW;
				end else begin
					cmd.div_sel = DSEL_FINAL;
					state_d     = S_FDIVW;
				end
			end
			S_FDIVW: begin
				if (sts.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/fractional_n_ratio_approximator_core.sv =====
// Top level of the fractional-N ratio approximator.
// Usage:
// - Input channel (in_valid/in_ready, target_freq): one target frequency per
//   transfer, FRAC_BITS fraction bits. in_ready is high only while the block is idle.
// - Output channel (out_valid/out_ready): one result per input transfer with
//   frac_numerator, frac_denominator, integer_part and status.
// - Config port (cfg_write, cfg_index, cfg_data): write only while idle.
// Sequence: setup, then one pass per continued-fraction term, then the
// semi-convergent when it is needed and the final split. Each term is
// dominated by one radix-2 division; the number of terms is capped by MAX_TERMS.
// A target below N times the reference skips the expansion and goes straight
// to the output with status low.
// Throughput: one item at a time; the next item is taken as soon as the result
// is in the output register.
// Reset clears the controller and output valid and loads the config defaults.
// If the receiver stalls, the finished result waits in the output register and
// the block holds the next result until that one is transferred.
module fractional_n_ratio_approximator_core import frna_pkg::*; #(
	parameter int FRAC_BITS = 8,
	parameter int MAX_TERMS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_W-1:0]      target_freq,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DEN_W-1:0]     frac_numerator,
	output logic [DEN_W-1:0]     frac_denominator,
	output logic [IP_W-1:0]      integer_part,
	output logic [ST_W-1:0]      status
);

	cmd_t cmd;
	sts_t sts;

	frna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frna_dp #(
		.FRAC_BITS (FRAC_BITS),
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.target_freq      (target_freq),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.frac_numerator   (frac_numerator),
		.frac_denominator (frac_denominator),
		.integer_part     (integer_part),
		.status           (status)
	);

endmodule

// ===== verif/tb.sv =====
// Testbench for the fractional-N ratio approximator: directed table plus random phases.
module tb;
	import frna_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [IP_W-1:0]  ip;
		status_t          st;
	} ratio_t;

	typedef struct {
		logic [IN_W-1:0] tgt;
		bit              typed;
		ratio_t          res;
	} row_t;

	localparam int WATCHDOG = 60000;
	localparam int LONG_HOLD = 6000;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [IN_W-1:0]      target_freq;
	logic                 out_valid;
	logic                 out_ready;
	logic [DEN_W-1:0]     frac_numerator;
	logic [DEN_W-1:0]     frac_denominator;
	logic [IP_W-1:0]      integer_part;
	logic [ST_W-1:0]      status;

	bit [63:0] sh_divider, sh_ref, sh_maxden;
	ratio_t    ratio_q[$];
	row_t      dir_tab[$];
	int        errors, n_sent, n_recv, n_low, n_ovr, n_phases, idle_cycles, burst_left;
	bit        hold_req;

	fractional_n_ratio_approximator_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.target_freq(target_freq), .out_valid(out_valid), .out_ready(out_ready),
		.frac_numerator(frac_numerator), .frac_denominator(frac_denominator),
		.integer_part(integer_part), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic ratio_t predict_ratio(logic [IN_W-1:0] tgt);
		bit [63:0] t, rf, lim, base, a, b, q, r, x, h1, h0, k1, k0, m, num, den, ip;
		ratio_t res;
		t = 64'(tgt);
		rf = (sh_ref != 0) ? sh_ref : 64'd1;
		lim = (sh_maxden != 0) ? sh_maxden : 64'd1;
		base = (sh_divider * rf) << 8;
		h1 = 1; h0 = 0; k1 = 0; k0 = 1;
		if (t < base) begin
			res = '{num: '0, den: '0, ip: '0, st: ST_LOW};
			return res;
		end
		a = t - base;
		b = rf << 8;
		for (int n = 0; n < 64; n++) begin
			q = a / b;
			r = a % b;
			if (k1 * q + k0 > lim) break;
			x = h1 * q + h0; h0 = h1; h1 = x;
			x = k1 * q + k0; k0 = k1; k1 = x;
			if (r == 0) break;
			if (r <= (b - 1) / 64'h7FFFFFFF) break;
			a = b;
			b = r;
		end
		if (!(k1 > 0 && h1 > 0)) begin
			m = (k1 != 0 && lim >= k0) ? (lim - k0) / k1 : 64'd0;
			h1 = h1 * m + h0;
			k1 = k1 * m + k0;
		end
		num = h1;
		den = (k1 != 0) ? k1 : 64'd1;
		ip = num / den;
		res.num = DEN_W'(num % den);
		res.den = DEN_W'(k1);
		if (ip > 64'hFFFF) begin
			res.ip = '1;
			res.st = ST_OVR;
		end else begin
			res.ip = IP_W'(ip);
			res.st = ST_OK;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_recv);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_DIVIDER:   sh_divider = 64'(val[N_W-1:0]);
			CFG_REFERENCE: sh_ref = 64'(val[REF_W-1:0]);
			CFG_MAXDEN:    sh_maxden = 64'(val[DEN_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic program_ratio(logic [CFG_W-1:0] n, logic [CFG_W-1:0] rf, logic [CFG_W-1:0] md);
		write_reg(CFG_DIVIDER, n);
		write_reg(CFG_REFERENCE, rf);
		write_reg(CFG_MAXDEN, md);
		if ($urandom_range(0, 1)) write_reg(CFG_NONE, CFG_W'($urandom));
		@(negedge clk);
		cfg_write <= 1'b0;
		n_phases++;
	endtask

	task automatic send_target(logic [IN_W-1:0] tgt, bit typed, ratio_t res);
		@(negedge clk);
		in_valid <= 1'b1;
		target_freq <= tgt;
		do @(posedge clk); while (!in_ready);
		ratio_q.push_back(typed ? res : predict_ratio(tgt));
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (ratio_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				out_ready <= 1'b0;
				hold_taken = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				case (($time / 768) % 3)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_recv++;
			if (ratio_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(status), 64'd0);
			end else begin
				if (frac_numerator !== ratio_q[0].num)
					report_mismatch("frac_numerator", 64'(frac_numerator),
						64'(ratio_q[0].num));
				if (frac_denominator !== ratio_q[0].den)
					report_mismatch("frac_denominator", 64'(frac_denominator),
						64'(ratio_q[0].den));
				if (integer_part !== ratio_q[0].ip)
					report_mismatch("integer_part", 64'(integer_part), 64'(ratio_q[0].ip));
				if (status !== ratio_q[0].st)
					report_mismatch("status", 64'(status), 64'(ratio_q[0].st));
				if (ratio_q[0].st == ST_LOW) n_low++;
				if (ratio_q[0].st == ST_OVR) n_ovr++;
				void'(ratio_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic row_t mk(logic [IN_W-1:0] tgt, bit low);
		row_t rw;
		rw.tgt = tgt;
		rw.typed = low;
		rw.res = '{num: '0, den: '0, ip: '0, st: ST_LOW};
		return rw;
	endfunction

	task automatic run_rows;
		foreach (dir_tab[i]) send_target(dir_tab[i].tgt, dir_tab[i].typed, dir_tab[i].res);
		drain();
		dir_tab.delete();
	endtask

	initial begin
		bit [63:0] rf, nmax, base, off, t;
		ratio_t none;
		none = '0;
		arst_n = 1'b0;
		cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; target_freq = '0;
		sh_divider = 341; sh_ref = 10000000; sh_maxden = 4194303;
		burst_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults after reset
		dir_tab = '{mk(40'd0, 1), mk(40'd872959999999, 1), mk(40'd872960000000, 0),
			mk(40'd872960000001, 0), mk(40'hFF_FFFF_FFFF, 0), mk(40'hAA_AAAA_AAAA, 0),
			mk(40'h55_5555_5555, 0), mk(40'd873813333333, 0)};
		run_rows();
		program_ratio(0, 1, 1);
		dir_tab = '{mk(40'd0, 0), mk(40'd1, 0), mk(40'd255, 0), mk(40'd256, 0),
			mk(40'hFF_FFFF_FFFF, 0), mk(40'h12_3456_789A, 0)};
		run_rows();
		// zero reference and zero max denominator behave as one
		program_ratio(4095, 0, 0);
		dir_tab = '{mk(40'd0, 1), mk(40'd1048319, 1), mk(40'd1048320, 0),
			mk(40'hFF_FFFF_FFFF, 0)};
		run_rows();
		program_ratio(4095, 134217727, 4194303);
		dir_tab = '{mk(40'hFF_FFFF_FFFF, 1), mk(40'd0, 1)};
		run_rows();
		program_ratio(341, 10000000, 7);
		dir_tab = '{mk(40'd873000000000, 0), mk(40'd875000000123, 0)};
		run_rows();

		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 3))
				0: rf = 64'($urandom_range(1, 1000));
				1: rf = 64'($urandom_range(9000000, 11000000));
				default: rf = 64'($urandom_range(1, 134217727));
			endcase
			nmax = 64'h1_0000_0000 / rf;
			if (nmax > 4095) nmax = 4095;
			program_ratio(CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(0, 32'(nmax))), CFG_W'(rf),
				CFG_W'((ph % 3 == 0) ? $urandom_range(1, 64)
					: (ph % 3 == 1) ? $urandom_range(1, 4194303) : 4194303));
			base = (sh_divider * ((sh_ref != 0) ? sh_ref : 1)) << 8;
			for (int i = 0; i < 34; i++) begin
				if (ph == 2 && i == 5) hold_req = 1'b1;
				if (ph == 5 && i == 10) drain();
				if ($urandom_range(0, 9) < 7) begin
					off = {$urandom, $urandom} >> $urandom_range(24, 63);
					t = base + off;
				end else begin
					t = {$urandom, $urandom};
				end
				send_target(t[IN_W-1:0], 0, none);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("sent %0d targets over %0d register settings, %0d results checked",
			n_sent, n_phases, n_recv);
		$display("results with target below N*ref: %0d, integer part saturated: %0d",
			n_low, n_ovr);
		if (errors == 0 && ratio_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
